FILE: design/vector_arith_norm_unit_macros.svh
// Assertion macros for the vector arithmetic and norm unit.
`ifndef VECTOR_ARITH_NORM_UNIT_MACROS_SVH
`define VECTOR_ARITH_NORM_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Implication checked on every edge outside reset.
`define VAN_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
// Implication checked on the next edge.
`define VAN_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define VAN_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define VAN_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: design/van_pkg.sv
// Types and constants shared by the vector arithmetic and norm unit.
package van_pkg;
	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_SCALE = 3'd2;
	localparam logic [2:0] OP_DOT = 3'd3;
	localparam logic [2:0] OP_NORM = 3'd4;
	localparam logic [2:0] OP_EQ = 3'd5;

	localparam logic [1:0] NK_SUM = 2'd0;
	localparam logic [1:0] NK_EUCL = 2'd1;
	localparam logic [1:0] NK_MAX = 2'd2;

	localparam logic [1:0] REG_OPERATION = 2'd0;
	localparam logic [1:0] REG_NORM_KIND = 2'd1;
	localparam logic [1:0] REG_SCALE = 2'd2;
	localparam logic [1:0] REG_TOL = 2'd3;

	typedef struct packed {
		logic [31:0] elem_a;
		logic [31:0] elem_b;
		logic last_element;
	} in_item_t;

	typedef struct packed {
		logic [63:0] value;
		logic is_equal;
		logic status;
		logic last;
	} out_item_t;

	// Classified item handed from the front to the back.
	typedef struct packed {
		logic [2:0] op;
		logic [1:0] nk;
		logic signed [32:0] diff;
		logic signed [63:0] prod;
		logic signed [32:0] sum;
		logic last;
	} work_t;
endpackage

FILE: design/van_front.sv
// Front part: decodes the operation, forms difference, sum and product.
module van_front #(
	parameter int DATA_BITS = 32
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input van_pkg::in_item_t in_data,
	input logic [2:0] operation,
	input logic [1:0] norm_kind,
	input logic [31:0] scale_factor,
	output logic w_valid,
	input logic w_stall,
	output van_pkg::work_t w_data
);
	import van_pkg::*;

	logic valid_s1, valid_s2;
	logic [2:0] op_s1;
	logic [1:0] nk_s1;
	logic last_s1;
	logic signed [31:0] a_s1, b_s1;
	logic signed [31:0] m_s1;
	work_t work_s2;
	logic adv;
	logic signed [31:0] a_x, b_x;
	logic signed [32:0] d_x, s_x;
	logic signed [63:0] p_x;

	// Bring the low DATA_BITS bits to full width as signed values.
	assign a_x = 32'(signed'(in_data.elem_a[DATA_BITS-1:0]));
	assign b_x = 32'(signed'(in_data.elem_b[DATA_BITS-1:0]));

	// Two stage pipe moves as a unit; invalid operations drop here.
	assign adv = !valid_s2 || !w_stall;
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid && (operation <= OP_EQ);
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1 <= operation;
			nk_s1 <= norm_kind;
			last_s1 <= in_data.last_element;
			a_s1 <= a_x;
			b_s1 <= b_x;
			m_s1 <= (operation == OP_SCALE) ? signed'(scale_factor) : b_x;
		end
	end

	// Stage two: one 32x32 multiplier plus add and subtract.
	assign d_x = 33'(a_s1) - 33'(b_s1);
	assign s_x = 33'(a_s1) + 33'(b_s1);
	assign p_x = 64'(a_s1) * 64'(m_s1);

	always_ff @(posedge clk) begin
		if (adv) begin
			work_s2.op <= op_s1;
			work_s2.nk <= nk_s1;
			work_s2.diff <= d_x;
			work_s2.sum <= s_x;
			work_s2.prod <= p_x;
			work_s2.last <= last_s1;
		end
	end

	assign w_valid = valid_s2;
	assign w_data = work_s2;
endmodule

FILE: design/van_queue.sv
// Short queue between the front and the back.
module van_queue #(
	parameter int DEPTH = 4
) (
	input logic clk,
	input logic arst_n,
	input logic wr_valid,
	output logic wr_stall,
	input van_pkg::work_t wr_data,
	output logic rd_valid,
	input logic rd_stall,
	output van_pkg::work_t rd_data
);
	import van_pkg::*;
	localparam int AW = $clog2(DEPTH);

	work_t mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;
	logic wr, rd;

	assign wr_stall = (cnt_q == (AW+1)'(DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign wr = wr_valid && !wr_stall;
	assign rd = rd_valid && !rd_stall;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			if (rd) rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
		end
	end
endmodule

FILE: design/van_back.sv
// Back part: square stage, accumulator, square root and output register.
`include "vector_arith_norm_unit_macros.svh"
module van_back (
	input logic clk,
	input logic arst_n,
	input logic w_valid,
	output logic w_stall,
	input van_pkg::work_t w_data,
	input logic [30:0] tolerance,
	output logic out_valid,
	input logic out_stall,
	output van_pkg::out_item_t out_data
);
	import van_pkg::*;

	localparam logic [1:0] ST_IN = 2'd0;
	localparam logic [1:0] ST_SQR = 2'd1;
	localparam logic [1:0] ST_SQRT = 2'd2;

	logic [1:0] st_q;
	work_t cur_q;
	logic [32:0] ad_q;
	logic signed [63:0] acc_q;
	logic ovf_q;
	logic [39:0] root_q;
	logic [43:0] rem_q;
	logic [79:0] rad_q;
	logic [5:0] bit_q;
	logic ov_q;
	out_item_t od_q;
	logic [32:0] ad_w;
	logic [65:0] sq_w;
	logic signed [63:0] addend, fq, sat_sum;
	logic signed [64:0] wide;
	logic sat;
	logic [43:0] rem_sh, trial;
	logic [39:0] tr, tf;
	logic tk;
	logic ocan;

	assign ocan = !ov_q || !out_stall;
	assign w_stall = !(st_q == ST_IN && ocan);
	assign ad_w = w_data.diff[32] ? 33'(-w_data.diff) : 33'(w_data.diff);
	// Floor of Q32.32 product to Q48.16 is an arithmetic shift.
	assign fq = w_data.prod >>> 16;
	assign sq_w = 66'(ad_q) * 66'(ad_q);

	// Addend for the reduction of the item in cur_q.
	always_comb begin
		if (cur_q.op == OP_DOT) addend = cur_q.prod >>> 16;
		else if (cur_q.nk == NK_SUM) addend = 64'(ad_q);
		else if (cur_q.nk == NK_EUCL) addend = 64'(sq_w >> 16);
		else addend = '0;
		wide = 65'(acc_q) + 65'(addend);
		sat = (wide[64] != wide[63]);
		sat_sum = sat ? (wide[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}}) : wide[63:0];
	end

	// One root bit per cycle: shift in two radicand bits, trial subtract.
	assign rem_sh = {rem_q[41:0], rad_q[79:78]};
	assign trial = rem_sh - {2'b00, root_q, 2'b01};
	assign tk = !trial[43];
	assign tr = {root_q[38:0], 1'b1};
	assign tf = {root_q[38:0], 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		logic ov_n;
		if (!arst_n) begin
			st_q <= ST_IN;
			acc_q <= '0;
			ovf_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			ov_n = ov_q && out_stall;
			unique case (st_q)
				ST_IN: begin
					if (w_valid && ocan) begin
						if (w_data.op <= OP_SCALE) begin
							ov_n = 1'b1;
							od_q.is_equal <= 1'b0;
							od_q.status <= 1'b0;
							od_q.last <= w_data.last;
							od_q.value <= (w_data.op == OP_ADD) ? 64'(w_data.sum) :
								(w_data.op == OP_SUB) ? 64'(w_data.diff) : fq;
							if (w_data.last) begin
								acc_q <= '0;
								ovf_q <= 1'b0;
							end
						end else begin
							st_q <= ST_SQR;
						end
					end
				end
				ST_SQR: begin
					// Fold this item into the accumulator.
					logic signed [63:0] na;
					logic no;
					logic signed [63:0] v;
					logic s;
					na = acc_q;
					no = ovf_q;
					if (cur_q.op == OP_DOT || cur_q.nk == NK_SUM || cur_q.nk == NK_EUCL) begin
						na = sat_sum;
						no = ovf_q | sat;
					end else if (cur_q.nk == NK_MAX) begin
						if ($signed(64'(ad_q)) > acc_q) na = 64'(ad_q);
					end
					v = (cur_q.op == OP_DOT || cur_q.nk != 2'd3) ? na : '0;
					s = no | (cur_q.op != OP_DOT && cur_q.nk == 2'd3);
					if (!cur_q.last) begin
						st_q <= ST_IN;
					end else if (cur_q.op != OP_DOT && cur_q.nk == NK_EUCL) begin
						root_q <= '0;
						rem_q <= '0;
						rad_q <= na[63] ? '0 : {na, 16'd0};
						bit_q <= 6'd39;
						st_q <= ST_SQRT;
					end else begin
						ov_n = 1'b1;
						od_q.value <= v;
						od_q.status <= s;
						od_q.is_equal <= (cur_q.op == OP_EQ) && !s &&
							(v <= signed'(64'(tolerance)));
						od_q.last <= 1'b1;
						na = '0;
						no = 1'b0;
						st_q <= ST_IN;
					end
					acc_q <= na;
					ovf_q <= no;
				end
				ST_SQRT: begin
					if (bit_q == '0) begin
						logic [39:0] r;
						r = tk ? tr : tf;
						if (ocan) begin
							ov_n = 1'b1;
							od_q.value <= 64'(r);
							od_q.status <= ovf_q;
							od_q.is_equal <= (cur_q.op == OP_EQ) && !ovf_q &&
								(64'(r) <= 64'(tolerance));
							od_q.last <= 1'b1;
							acc_q <= '0;
							ovf_q <= 1'b0;
							st_q <= ST_IN;
						end
					end else begin
						rem_q <= tk ? trial : rem_sh;
						root_q <= tk ? tr : tf;
						rad_q <= rad_q << 2;
						bit_q <= bit_q - 1'b1;
					end
				end
				default: st_q <= ST_IN;
			endcase
			ov_q <= ov_n;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_IN && w_valid && ocan) begin
			cur_q <= w_data;
			ad_q <= ad_w;
		end
	end

	assign out_valid = ov_q;
	assign out_data = od_q;

	`VAN_ASSERT_IMP(a_state_ok, clk, arst_n, 1'b1, st_q != 2'd3)
	`VAN_ASSERT_IMP(a_busy_stalls, clk, arst_n, st_q != ST_IN, w_stall)
	`VAN_ASSERT_NXT(a_out_hold, clk, arst_n, ov_q && out_stall, ov_q && $stable(od_q))
endmodule

FILE: design/vector_arith_norm_unit.sv
// Top level of the vector arithmetic and norm unit.
//  channel | signals                                    | transfer when
//  in      | in_valid, in_stall, in_data                | in_valid && !in_stall
//  out     | out_valid, out_stall, out_data             | out_valid && !out_stall
//  cfg     | cfg_we, cfg_index, cfg_data                | cfg_we
// Element-wise items pass only the input state of the back; reduction items also
// the accumulator fold, and the last item of a Euclidean norm then the bit-serial
// square root loop.
// Reset clears pipeline, queue, accumulator and registers to their defaults.
// Either side may stall; the queue absorbs the front's pipeline.
module vector_arith_norm_unit #(
	parameter int DATA_BITS = 32
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input van_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_stall,
	output van_pkg::out_item_t out_data,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [31:0] cfg_data
);
	import van_pkg::*;

	logic [2:0] op_q;
	logic [1:0] nk_q;
	logic [31:0] sf_q;
	logic [30:0] tol_q;
	logic fv, fs, bv, bs;
	work_t fd, bd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= OP_ADD;
			nk_q <= NK_EUCL;
			sf_q <= 32'd65536;
			tol_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_OPERATION: op_q <= cfg_data[2:0];
				REG_NORM_KIND: nk_q <= cfg_data[1:0];
				REG_SCALE: sf_q <= cfg_data;
				default: tol_q <= cfg_data[30:0];
			endcase
		end
	end

	van_front #(.DATA_BITS(DATA_BITS)) u_front (
		.clk, .arst_n, .in_valid, .in_stall, .in_data,
		.operation(op_q), .norm_kind(nk_q), .scale_factor(sf_q),
		.w_valid(fv), .w_stall(fs), .w_data(fd)
	);

	van_queue #(.DEPTH(4)) u_queue (
		.clk, .arst_n, .wr_valid(fv), .wr_stall(fs), .wr_data(fd),
		.rd_valid(bv), .rd_stall(bs), .rd_data(bd)
	);

	van_back u_back (
		.clk, .arst_n, .w_valid(bv), .w_stall(bs), .w_data(bd),
		.tolerance(tol_q), .out_valid, .out_stall, .out_data
	);
endmodule
